// ===== hdl/upb_pkg.sv =====
// ---------------------------------------------------------------------------
// upb_pkg
// Shared constants and controller/datapath interface types for the UDP/IPv4
// packet builder.
// ---------------------------------------------------------------------------
`default_nettype none

package upb_pkg;

	localparam int PAYLOAD_CAPACITY = 484;
	localparam int HDR_BYTES        = 28;
	localparam int PKT_MAX          = HDR_BYTES + PAYLOAD_CAPACITY;
	localparam int WORD_BYTES       = 8;
	localparam int ROW_COUNT        = (PKT_MAX + WORD_BYTES - 1) / WORD_BYTES;
	localparam int ROW_W            = $clog2(ROW_COUNT);
	localparam int COUNT_W          = $clog2(PAYLOAD_CAPACITY + 1);
	localparam int LEN_W            = $clog2(PKT_MAX + 1);
	localparam int PKT_IDX_W        = $clog2(PKT_MAX);

	localparam logic [7:0] VER_IHL   = 8'h45;
	localparam logic [7:0] TTL_VALUE = 8'd128;
	localparam logic [7:0] PROTO_UDP = 8'h11;

	// Checksum sequencer: header terms on steps 0..8, two folds after that.
	localparam int          SUM_STEP_W    = 4;
	localparam logic [SUM_STEP_W-1:0] SUM_LAST_STEP = 4'd10;

	localparam logic [1:0] ACT_APPEND      = 2'd0;
	localparam logic [1:0] ACT_APPEND_SEND = 2'd1;
	localparam logic [1:0] ACT_SEND        = 2'd2;

	localparam logic [1:0] REG_SRC_ADDR = 2'd0;
	localparam logic [1:0] REG_DST_ADDR = 2'd1;
	localparam logic [1:0] REG_SRC_PORT = 2'd2;
	localparam logic [1:0] REG_DST_PORT = 2'd3;

	typedef struct packed {
		logic append;
		logic sum_step;
		logic emit;
		logic clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sum_last;
		logic emit_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/upb_ctrl.sv =====
// ---------------------------------------------------------------------------
// upb_ctrl
// Controller state machine: decodes accepted items and sequences the
// checksum steps, the word emission and the final buffer clear.
// ---------------------------------------------------------------------------
`default_nettype none

module upb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          action,
	input  wire upb_pkg::dp_status_t status,
	output logic                     busy,
	output upb_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.append = action inside {upb_pkg::ACT_APPEND, upb_pkg::ACT_APPEND_SEND};
					if (action inside {upb_pkg::ACT_APPEND_SEND, upb_pkg::ACT_SEND}) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (status.sum_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// The last word is being assembled; the buffer empties at this edge.
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/upb_datapath.sv =====
// ---------------------------------------------------------------------------
// upb_datapath
// Payload store in eight byte lanes, running sum, checksum accumulator,
// header assembly and the two-stage word read and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module upb_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire upb_pkg::ctrl_cmd_t cmd,
	output upb_pkg::dp_status_t     status,
	input  wire logic [7:0]         payload_byte,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [31:0]        wr_data,
	output logic                    strobe,
	output logic [63:0]             packet_word,
	output logic [3:0]              bytes_valid,
	output logic                    last_word,
	output logic                    truncated
);

	localparam int WB = upb_pkg::WORD_BYTES;
	localparam logic [upb_pkg::SUM_STEP_W-1:0] STEP_FOLD_HI  = 4'd9;
	localparam logic [upb_pkg::SUM_STEP_W-1:0] STEP_FOLD_END = upb_pkg::SUM_LAST_STEP;

	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;

	logic [upb_pkg::COUNT_W-1:0] count_q;
	logic [31:0]                 sum_q;
	logic                        ovf_q;

	logic [upb_pkg::SUM_STEP_W-1:0] step_q;
	logic [31:0]                    acc_q;
	logic [15:0]                    cks_q;

	logic [upb_pkg::ROW_W-1:0] word_q;
	logic [upb_pkg::ROW_W-1:0] word_s1;
	logic                      vld_s1;
	logic [7:0]                rd_s1 [WB];

	logic [upb_pkg::LEN_W-1:0]     total_len;
	logic [upb_pkg::LEN_W-1:0]     udp_len;
	logic [upb_pkg::PKT_IDX_W-1:0] wr_pos;
	logic                          space_ok;
	logic                          do_write;
	logic [upb_pkg::LEN_W-1:0]     issue_rem;
	logic [upb_pkg::LEN_W-1:0]     out_rem;
	logic [15:0]                   sum_term;
	logic [15:0]                   fold_sum;
	logic [223:0]                  hdr;
	logic [63:0]                   mem_word;
	logic [63:0]                   raw_word;
	logic [63:0]                   word_d;
	logic [3:0]                    bv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				upb_pkg::REG_SRC_ADDR: src_addr_q <= wr_data;
				upb_pkg::REG_DST_ADDR: dst_addr_q <= wr_data;
				upb_pkg::REG_SRC_PORT: src_port_q <= wr_data[15:0];
				upb_pkg::REG_DST_PORT: dst_port_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign total_len = upb_pkg::LEN_W'(count_q) + upb_pkg::LEN_W'(upb_pkg::HDR_BYTES);
	assign udp_len   = upb_pkg::LEN_W'(count_q) + upb_pkg::LEN_W'(WB);
	assign space_ok  = (count_q < upb_pkg::COUNT_W'(upb_pkg::PAYLOAD_CAPACITY));
	assign do_write  = cmd.append && space_ok;
	// Payload is stored at its packet offset, so word k reads row k of every lane.
	assign wr_pos    = upb_pkg::PKT_IDX_W'(total_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.append) begin
			if (space_ok) begin
				count_q <= count_q + 1'b1;
				if (count_q[0]) begin
					sum_q <= sum_q + {24'd0, payload_byte};
				end else begin
					sum_q <= sum_q + {16'd0, payload_byte, 8'd0};
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	for (genvar i = 0; i < WB; i++) begin : g_lane
		logic [7:0] lane_mem [upb_pkg::ROW_COUNT];

		always_ff @(posedge clk) begin
			if (do_write && (wr_pos[2:0] == 3'(i))) begin
				lane_mem[wr_pos[upb_pkg::PKT_IDX_W-1:3]] <= payload_byte;
			end
			if (cmd.emit) begin
				rd_s1[i] <= lane_mem[word_q];
			end
		end
	end

	always_comb begin
		case (step_q)
			4'd0:    sum_term = src_addr_q[31:16];
			4'd1:    sum_term = src_addr_q[15:0];
			4'd2:    sum_term = dst_addr_q[31:16];
			4'd3:    sum_term = dst_addr_q[15:0];
			4'd4:    sum_term = {8'd0, upb_pkg::PROTO_UDP};
			4'd5:    sum_term = 16'(udp_len);
			4'd6:    sum_term = src_port_q;
			4'd7:    sum_term = dst_port_q;
			4'd8:    sum_term = 16'(udp_len);
			default: sum_term = '0;
		endcase
	end

	assign fold_sum = acc_q[15:0] + {15'd0, acc_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.sum_step) begin
			step_q <= step_q + 1'b1;
		end else begin
			step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_step) begin
			if (step_q == '0) begin
				acc_q <= sum_q + {16'd0, sum_term};
			end else if (step_q == STEP_FOLD_HI) begin
				acc_q <= {16'd0, acc_q[31:16]} + {16'd0, acc_q[15:0]};
			end else if (step_q == STEP_FOLD_END) begin
				// A checksum of zero goes out as all ones.
				cks_q <= (fold_sum == 16'hFFFF) ? 16'hFFFF : ~fold_sum;
			end else begin
				acc_q <= acc_q + {16'd0, sum_term};
			end
		end
	end

	assign status.sum_last  = (step_q == upb_pkg::SUM_LAST_STEP);
	assign issue_rem        = total_len - upb_pkg::LEN_W'({word_q, 3'b000});
	assign status.emit_last = (issue_rem <= upb_pkg::LEN_W'(WB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.emit;
			if (cmd.emit) begin
				word_q <= word_q + 1'b1;
			end else begin
				word_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_s1 <= word_q;
		end
	end

	assign hdr = {upb_pkg::VER_IHL, 8'd0, 16'(total_len), 32'd0,
		upb_pkg::TTL_VALUE, upb_pkg::PROTO_UDP, 16'd0,
		src_addr_q, dst_addr_q, src_port_q, dst_port_q, 16'(udp_len), cks_q};

	assign out_rem = total_len - upb_pkg::LEN_W'({word_s1, 3'b000});

	always_comb begin
		for (int i = 0; i < WB; i++) begin
			mem_word[63-8*i -: 8] = rd_s1[i];
		end
		case (word_s1)
			6'd0:    raw_word = hdr[223:160];
			6'd1:    raw_word = hdr[159:96];
			6'd2:    raw_word = hdr[95:32];
			6'd3:    raw_word = {hdr[31:0], mem_word[31:0]};
			default: raw_word = mem_word;
		endcase
		bv_d = (out_rem > upb_pkg::LEN_W'(WB)) ? 4'd8 : out_rem[3:0];
		// Lanes past the end of the packet hold stale bytes and are cleared.
		for (int i = 0; i < WB; i++) begin
			word_d[63-8*i -: 8] = (4'(i) < bv_d) ? raw_word[63-8*i -: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			packet_word <= word_d;
			bytes_valid <= bv_d;
			last_word   <= (out_rem <= upb_pkg::LEN_W'(WB));
			truncated   <= ovf_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/udp_ipv4_packet_builder.sv =====
// ---------------------------------------------------------------------------
// udp_ipv4_packet_builder
// Collects payload bytes and sends them as a UDP/IPv4 packet in 64-bit
// big-endian words with a computed UDP checksum.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start, busy          action, payload_byte
//  result    strobe (no stall)    packet_word, bytes_valid, last_word, truncated
//  config    wr_en                wr_index, wr_data
//
// An append item does not make the block busy; the next item may follow at once.
// A send keeps busy high for eleven checksum sequencer steps, one payload-store
// row read for each of the W = ceil((28 + payload bytes) / 8) words and a
// flush state. Words appear on consecutive cycles through the row-read and
// output registers, the last one in the first cycle after busy falls. Reset
// clears all control state; the payload store needs no clearing pass.
`default_nettype none

module udp_ipv4_packet_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	output logic             strobe,
	output logic [63:0]      packet_word,
	output logic [3:0]       bytes_valid,
	output logic             last_word,
	output logic             truncated
);

	upb_pkg::ctrl_cmd_t  cmd;
	upb_pkg::dp_status_t status;

	upb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	upb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.payload_byte (payload_byte),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.strobe       (strobe),
		.packet_word  (packet_word),
		.bytes_valid  (bytes_valid),
		.last_word    (last_word),
		.truncated    (truncated)
	);

endmodule

`default_nettype wire

// ===== hdl/upb_checker.sv =====
// ---------------------------------------------------------------------------
// upb_checker
// Port-level checks on packet framing, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module upb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] action,
	input wire logic       strobe,
	input wire logic [3:0] bytes_valid,
	input wire logic       last_word,
	input wire logic       truncated
);

	// Every word but the last of a packet is full.
	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |-> bytes_valid == 4'd8)
		else $error("non-final word is not full");

	// Words of one packet come on back-to-back cycles.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |=> strobe)
		else $error("gap inside a packet");

	// The truncation flag is the same on every word of a packet.
	a_trunc_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |=> truncated == $past(truncated))
		else $error("truncated changed within a packet");

	// A send item makes the block busy.
	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == upb_pkg::ACT_APPEND_SEND || action == upb_pkg::ACT_SEND)
		|=> busy)
		else $error("send accepted without going busy");

	// No word is shown while a fresh item could still be accepted mid-packet.
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |-> busy)
		else $error("packet word outside a send");

endmodule

bind udp_ipv4_packet_builder upb_checker u_upb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.strobe      (strobe),
	.bytes_valid (bytes_valid),
	.last_word   (last_word),
	.truncated   (truncated)
);

`default_nettype wire

// ===== test/udp_ipv4_packet_builder_tb.sv =====
// ---------------------------------------------------------------------------
// udp_ipv4_packet_builder_tb
// Drives payload bytes and send commands into the packet builder and predicts
// every 64-bit packet word it sends: the IPv4 and UDP headers, the UDP
// checksum with its zero case, the payload, and the truncation flag. Directed
// cases come first, then random packets at three sender idle rates.
// ---------------------------------------------------------------------------
module udp_ipv4_packet_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        trunc;
	} word_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  payload_byte;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	logic        strobe;
	logic [63:0] packet_word;
	logic [3:0]  bytes_valid;
	logic        last_word;
	logic        truncated;

	udp_ipv4_packet_builder DUT (.*);

	always #10 clk = ~clk;

	// Local copy of the block's registers and payload state.
	logic [31:0] cfg_src_addr = '0;
	logic [31:0] cfg_dst_addr = '0;
	logic [15:0] cfg_src_port = '0;
	logic [15:0] cfg_dst_port = '0;
	logic [7:0]  stored_bytes [upb_pkg::PAYLOAD_CAPACITY];
	int unsigned stored_count = 0;
	logic [31:0] payload_sum = '0;
	logic        bytes_dropped = 1'b0;

	word_result_t expected_words [$];
	int unsigned  gap_pct = 0;
	int unsigned  items_sent = 0;
	int unsigned  packets_built = 0;
	int unsigned  words_checked = 0;
	int unsigned  error_count = 0;

	function automatic void append_payload_byte(logic [7:0] b);
		if (stored_count < upb_pkg::PAYLOAD_CAPACITY) begin
			stored_bytes[stored_count] = b;
			if (stored_count % 2 == 0)
				payload_sum += {16'h0, b, 8'h00};
			else
				payload_sum += {24'h0, b};
			stored_count++;
		end else begin
			bytes_dropped = 1'b1;
		end
	endfunction

	function automatic void build_packet_words();
		logic [7:0]   pkt [upb_pkg::PKT_MAX];
		logic [15:0]  total;
		logic [15:0]  udp_len;
		logic [31:0]  acc;
		logic [15:0]  cks;
		int unsigned  n_words;
		int unsigned  n;
		word_result_t w;
		total = 16'(upb_pkg::HDR_BYTES + stored_count);
		udp_len = 16'(8 + stored_count);
		foreach (pkt[i])
			pkt[i] = 8'h00;
		pkt[0] = upb_pkg::VER_IHL;
		pkt[2] = total[15:8];
		pkt[3] = total[7:0];
		pkt[8] = upb_pkg::TTL_VALUE;
		pkt[9] = upb_pkg::PROTO_UDP;
		for (int i = 0; i < 4; i++) begin
			pkt[12 + i] = cfg_src_addr[31 - 8 * i -: 8];
			pkt[16 + i] = cfg_dst_addr[31 - 8 * i -: 8];
		end
		pkt[20] = cfg_src_port[15:8];
		pkt[21] = cfg_src_port[7:0];
		pkt[22] = cfg_dst_port[15:8];
		pkt[23] = cfg_dst_port[7:0];
		pkt[24] = udp_len[15:8];
		pkt[25] = udp_len[7:0];

		// Pseudo-header, UDP header and payload, folded twice.
		acc = payload_sum + cfg_src_addr[31:16] + cfg_src_addr[15:0]
			+ cfg_dst_addr[31:16] + cfg_dst_addr[15:0] + upb_pkg::PROTO_UDP + udp_len
			+ cfg_src_port + cfg_dst_port + udp_len;
		acc = acc[31:16] + acc[15:0];
		acc = acc + (acc >> 16);
		cks = ~acc[15:0];
		if (cks == 16'h0000)
			cks = 16'hFFFF;
		pkt[26] = cks[15:8];
		pkt[27] = cks[7:0];

		for (int i = 0; i < stored_count; i++)
			pkt[upb_pkg::HDR_BYTES + i] = stored_bytes[i];

		n_words = (total + 7) / 8;
		for (int k = 0; k < n_words; k++) begin
			n = total - k * 8;
			if (n > 8)
				n = 8;
			w.word = '0;
			for (int i = 0; i < 8; i++)
				w.word = {w.word[55:0], (i < n) ? pkt[k * 8 + i] : 8'h00};
			w.nbytes = 4'(n);
			w.last = (k + 1 == n_words);
			w.trunc = bytes_dropped;
			expected_words.push_back(w);
		end

		packets_built++;
		stored_count = 0;
		payload_sum = '0;
		bytes_dropped = 1'b0;
	endfunction

	// Called in the time step of a clock edge. start stays high when items
	// follow back to back.
	task automatic send_item(input logic [1:0] act, input logic [7:0] b);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		payload_byte <= b;
		do
			@(posedge clk);
		while (busy);
		case (act)
			upb_pkg::ACT_APPEND: append_payload_byte(b);
			upb_pkg::ACT_APPEND_SEND: begin
				append_payload_byte(b);
				build_packet_words();
			end
			upb_pkg::ACT_SEND: build_packet_words();
			default: ;
		endcase
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_config(input logic [31:0] sa, input logic [31:0] da,
		input logic [15:0] sp, input logic [15:0] dp);
		write_reg(upb_pkg::REG_SRC_ADDR, sa);
		write_reg(upb_pkg::REG_DST_ADDR, da);
		write_reg(upb_pkg::REG_SRC_PORT, {16'h0, sp});
		write_reg(upb_pkg::REG_DST_PORT, {16'h0, dp});
		wr_en <= 1'b0;
		cfg_src_addr = sa;
		cfg_dst_addr = da;
		cfg_src_port = sp;
		cfg_dst_port = dp;
	endtask

	task automatic test_directed();
		gap_pct = 20;
		// Reset configuration: empty packet, ignored code, single byte.
		send_item(upb_pkg::ACT_SEND, 8'h00);
		send_item(ACT_UNUSED, 8'hFF);
		send_item(upb_pkg::ACT_APPEND_SEND, 8'hFF);
		wait_drained();
		write_config('1, '1, '1, '1);
		send_item(upb_pkg::ACT_APPEND, 8'h00);
		send_item(upb_pkg::ACT_APPEND, 8'hFF);
		send_item(upb_pkg::ACT_APPEND_SEND, 8'h80);
		send_item(upb_pkg::ACT_APPEND, 8'h01);
		send_item(ACT_UNUSED, 8'h00);
		send_item(upb_pkg::ACT_APPEND, 8'hFE);
		send_item(upb_pkg::ACT_SEND, 8'h55);
		send_item(upb_pkg::ACT_SEND, 8'h00);
	endtask

	task automatic test_zero_checksum();
		// The header terms of an empty packet sum to 0xFFFF here, so the
		// checksum computes to zero and must go out as all ones.
		wait_drained();
		write_config(32'hFFDE_0000, 32'h0, 16'h0, 16'h0);
		send_item(upb_pkg::ACT_SEND, 8'h00);
	endtask

	task automatic test_buffer_full();
		wait_drained();
		write_config($urandom, $urandom, 16'($urandom), 16'($urandom));
		// Fill to capacity; the sending byte then finds no room and is dropped.
		for (int i = 0; i < upb_pkg::PAYLOAD_CAPACITY; i++)
			send_item(upb_pkg::ACT_APPEND, 8'($urandom));
		send_item(upb_pkg::ACT_APPEND_SEND, 8'($urandom));
	endtask

	task automatic test_random_packets(input int unsigned idle_pct,
		input int unsigned item_goal);
		int unsigned goal_end;
		int unsigned len;
		int unsigned pick;
		wait_drained();
		write_config($urandom, $urandom, 16'($urandom), 16'($urandom));
		gap_pct = idle_pct;
		goal_end = items_sent + item_goal;
		while (items_sent < goal_end) begin
			pick = $urandom_range(99);
			if (pick < 85)
				len = $urandom_range(15);
			else
				len = $urandom_range(40, 16);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 3)
					send_item(ACT_UNUSED, 8'($urandom));
				send_item(upb_pkg::ACT_APPEND, 8'($urandom));
			end
			send_item($urandom_range(1) ? upb_pkg::ACT_APPEND_SEND : upb_pkg::ACT_SEND,
				8'($urandom));
		end
	endtask

	always @(posedge clk) begin
		word_result_t exp_w;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				$error("unexpected packet word %h", packet_word);
				error_count++;
			end else begin
				exp_w = expected_words.pop_front();
				words_checked++;
				if (packet_word !== exp_w.word) begin
					$error("packet_word: expected %h, got %h", exp_w.word, packet_word);
					error_count++;
				end
				if (bytes_valid !== exp_w.nbytes) begin
					$error("bytes_valid: expected %0d, got %0d", exp_w.nbytes, bytes_valid);
					error_count++;
				end
				if (last_word !== exp_w.last) begin
					$error("last_word: expected %b, got %b", exp_w.last, last_word);
					error_count++;
				end
				if (truncated !== exp_w.trunc) begin
					$error("truncated: expected %b, got %b", exp_w.trunc, truncated);
					error_count++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("[udp_ipv4_packet_builder] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= upb_pkg::ACT_APPEND;
		payload_byte <= 8'h00;
		wr_en <= 1'b0;
		wr_index <= upb_pkg::REG_SRC_ADDR;
		wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zero_checksum();
		test_buffer_full();
		test_random_packets(20, 30);
		test_random_packets(69, 30);
		test_random_packets(0, 30);
		wait_drained();

		$display("Sent %0d items in %0d packets at sender idle rates of 20, 69 and 0 percent.",
			items_sent, packets_built);
		$display("Checked %0d packet words, including empty, odd, full and overflowing payloads.",
			words_checked);
		if (error_count == 0)
			$display("[udp_ipv4_packet_builder] OK");
		else
			$display("[udp_ipv4_packet_builder] ERROR");
		$finish;
	end

endmodule
